// ===== hw/rtl/vgar_pkg.sv =====
// shared types, codes and field layout for the video gate array register file
package vgar_pkg;

  // stream widths
  localparam int unsigned S_TDATA_W = 16;
  localparam int unsigned S_TUSER_W = 2;
  localparam int unsigned M_TDATA_W = 104;

  // configuration port
  localparam int unsigned CFG_ADDR_W  = 3;
  localparam int unsigned CFG_DATA_W  = 32;
  localparam int unsigned RAM_BASE_W  = 20;
  localparam logic [CFG_ADDR_W-1:0] REG_RAM_BASE = 3'd0;

  localparam int unsigned PALETTE_ENTRIES = 16;
  localparam int unsigned PAL_IDX_W       = $clog2(PALETTE_ENTRIES);

  localparam logic [RAM_BASE_W-1:0] UNMAPPED_BASE = 20'hA0000;
  localparam logic [15:0]           WIN_SMALL     = 16'h4000;
  localparam logic [15:0]           WIN_LARGE     = 16'h8000;

  typedef enum logic [1:0] {
    CMD_WRITE   = 2'd0,
    CMD_STATUS  = 2'd1,
    CMD_ROW_END = 2'd2,
    CMD_TICK    = 2'd3
  } cmd_e;

  // port offsets
  localparam logic [3:0] PORT_MODE   = 4'd8;
  localparam logic [3:0] PORT_COLOR  = 4'd9;
  localparam logic [3:0] PORT_ADDR   = 4'd10;
  localparam logic [3:0] PORT_DATA   = 4'd14;
  localparam logic [3:0] PORT_PAGE   = 4'd15;

  // array addresses below the palette range
  localparam logic [7:0] ARR_MASK     = 8'd1;
  localparam logic [7:0] ARR_BORDER   = 8'd2;
  localparam logic [7:0] ARR_EXT_MODE = 8'd3;

  // address mode field of a page write
  localparam logic [1:0] PG_AM_ALPHA = 2'd0;
  localparam logic [1:0] PG_AM_LOW   = 2'd1;
  localparam logic [1:0] PG_AM_HIGH  = 2'd3;

  typedef enum logic [1:0] {
    AM_ALPHA    = 2'd0,
    AM_GFX_LOW  = 2'd1,
    AM_GFX_HIGH = 2'd2
  } addr_mode_e;

  localparam logic [2:0] DRAW_TEXT    = 3'd0;
  localparam logic [2:0] DRAW_320X4   = 3'd1;
  localparam logic [2:0] DRAW_640X2   = 3'd2;
  localparam logic [2:0] DRAW_640X4   = 3'd3;
  localparam logic [2:0] DRAW_16COLOR = 3'd4;

  localparam logic [3:0] CHAR_NARROW = 4'd4;
  localparam logic [3:0] CHAR_WIDE   = 4'd8;

  // mode control bits
  localparam int unsigned MB_HI_DOT   = 0;
  localparam int unsigned MB_GRAPHICS = 1;
  localparam int unsigned MB_MONO     = 2;
  localparam int unsigned MB_HI_RES   = 4;
  // extended mode bits
  localparam int unsigned EB_BORDER = 0;
  localparam int unsigned EB_640X4  = 1;
  localparam int unsigned EB_16COL  = 2;

  typedef struct packed {
    cmd_e       cmd;
    logic [3:0] port_offset;
    logic [7:0] write_data;
    logic       display_area;
    logic       vsync;
  } item_t;

  typedef struct packed {
    logic [7:0]            read_data;
    logic [2:0]            draw_mode;
    logic [3:0]            char_width;
    logic [RAM_BASE_W-1:0] crt_base;
    logic [RAM_BASE_W-1:0] cpu_base;
    logic                  window_valid;
    logic [15:0]           window_size;
    addr_mode_e            address_mode;
    logic [15:0]           row_palette;
    logic [3:0]            border_color;
    logic [3:0]            palette_mask;
    logic                  tick_enable;
  } result_t;

  // output tdata layout, lowest bit of each field
  localparam int unsigned OF_READ_DATA = 0;
  localparam int unsigned OF_DRAW_MODE = 8;
  localparam int unsigned OF_CHAR_W    = 11;
  localparam int unsigned OF_CRT_BASE  = 15;
  localparam int unsigned OF_CPU_BASE  = 35;
  localparam int unsigned OF_WIN_VALID = 55;
  localparam int unsigned OF_WIN_SIZE  = 56;
  localparam int unsigned OF_ADDR_MODE = 72;
  localparam int unsigned OF_ROW_PAL   = 74;
  localparam int unsigned OF_BORDER    = 90;
  localparam int unsigned OF_MASK      = 94;
  localparam int unsigned OF_TICK      = 98;

endpackage

// ===== hw/rtl/vgar_in_reg.sv =====
// input register stage for accepted transactions
module vgar_in_reg import vgar_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  item_t in_item_i,
  output logic  valid_o,
  input  logic  take_i,
  output item_t item_o
);

  logic  valid_q, valid_d;
  item_t item_q;

  assign in_ready_o = !valid_q || take_i;
  assign valid_d    = in_valid_i || (valid_q && !take_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ===== hw/rtl/vgar_core.sv =====
// register state, port decode and result computation
module vgar_core import vgar_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  fire_i,
  input  item_t                 item_i,
  input  logic [RAM_BASE_W-1:0] ram_base_i,
  output result_t               result_o
);

  logic [5:0]  mode_q, mode_d;
  logic [2:0]  ext_q, ext_d;
  logic [5:0]  color_q, color_d;
  logic [2:0]  crt_page_q, crt_page_d;
  logic [2:0]  cpu_page_q, cpu_page_d;
  addr_mode_e  am_q, am_d;
  logic [7:0]  arr_addr_q, arr_addr_d;
  logic [3:0]  pal_q [PALETTE_ENTRIES];
  logic [3:0]  mask_q, mask_d;
  logic [3:0]  border_q, border_d;
  logic [15:0] row_pal_q, row_pal_d;
  logic        div_q, div_d;
  logic        pal_we;
  logic        tick;
  logic [7:0]  rd;
  logic [3:0]  entry0;
  logic        mono;
  logic        is_write;

  assign is_write = (item_i.cmd == CMD_WRITE);
  assign mono     = color_q[5] & ~mode_q[MB_MONO] | mode_q[MB_MONO];

  always_comb begin
    mode_d     = mode_q;
    ext_d      = ext_q;
    color_d    = color_q;
    crt_page_d = crt_page_q;
    cpu_page_d = cpu_page_q;
    am_d       = am_q;
    arr_addr_d = arr_addr_q;
    mask_d     = mask_q;
    border_d   = border_q;
    row_pal_d  = row_pal_q;
    div_d      = div_q;
    pal_we     = 1'b0;
    tick       = 1'b0;
    rd         = 8'd0;
    entry0     = ext_q[EB_BORDER] ? border_q : color_q[3:0];
    case (item_i.cmd)
      CMD_WRITE: begin
        case (item_i.port_offset)
          PORT_MODE:  mode_d     = item_i.write_data[5:0];
          PORT_COLOR: color_d    = item_i.write_data[5:0];
          PORT_ADDR:  arr_addr_d = item_i.write_data;
          PORT_DATA: begin
            if (arr_addr_q[4]) begin
              pal_we = 1'b1;
            end else if (arr_addr_q == ARR_MASK) begin
              mask_d = item_i.write_data[3:0];
            end else if (arr_addr_q == ARR_BORDER) begin
              border_d = item_i.write_data[3:0];
            end else if (arr_addr_q == ARR_EXT_MODE) begin
              ext_d = item_i.write_data[4:2];
            end
          end
          PORT_PAGE: begin
            crt_page_d = item_i.write_data[2:0];
            cpu_page_d = item_i.write_data[5:3];
            // graphics with the high dot clock pairs pages
            if (mode_q[MB_GRAPHICS] && mode_q[MB_HI_DOT]) begin
              crt_page_d[0] = 1'b0;
            end
            case (item_i.write_data[7:6])
              PG_AM_ALPHA: am_d = AM_ALPHA;
              PG_AM_LOW:   am_d = AM_GFX_LOW;
              PG_AM_HIGH:  am_d = AM_GFX_HIGH;
              default:     am_d = am_q;
            endcase
          end
          default: ;
        endcase
      end
      CMD_STATUS: begin
        if (item_i.port_offset == PORT_ADDR) begin
          rd = {4'd0, item_i.vsync, 1'b1, 1'b0, ~item_i.display_area};
        end
      end
      CMD_ROW_END: begin
        row_pal_d[3:0] = entry0;
        for (int i = 1; i < 4; i++) begin
          row_pal_d[4*i +: 4] = {color_q[4], 2'(i), mono & (~mode_q[MB_MONO] | 1'(i))};
        end
      end
      CMD_TICK: begin
        if (mode_q[MB_HI_DOT]) begin
          tick = 1'b1;
        end else begin
          div_d = ~div_q;
          tick  = div_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= '0;
      ext_q      <= '0;
      color_q    <= '0;
      crt_page_q <= '0;
      cpu_page_q <= '0;
      am_q       <= AM_ALPHA;
      arr_addr_q <= '0;
      mask_q     <= '0;
      border_q   <= '0;
      row_pal_q  <= '0;
      div_q      <= 1'b0;
    end else if (fire_i) begin
      mode_q     <= mode_d;
      ext_q      <= ext_d;
      color_q    <= color_d;
      crt_page_q <= crt_page_d;
      cpu_page_q <= cpu_page_d;
      am_q       <= am_d;
      arr_addr_q <= arr_addr_d;
      mask_q     <= mask_d;
      border_q   <= border_d;
      row_pal_q  <= row_pal_d;
      div_q      <= div_d;
    end
  end

  // palette registers, written through the data port; no output of this block reads them
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < PALETTE_ENTRIES; i++) begin
        pal_q[i] <= '0;
      end
    end else if (fire_i && is_write && pal_we) begin
      pal_q[arr_addr_q[PAL_IDX_W-1:0]] <= item_i.write_data[3:0];
    end
  end

  // result reflects the state after this transaction
  always_comb begin
    result_o.read_data = rd;
    if (!mode_d[MB_GRAPHICS]) begin
      result_o.draw_mode = DRAW_TEXT;
    end else if (mode_d[MB_HI_RES]) begin
      result_o.draw_mode = ext_d[EB_640X4] ? DRAW_640X4 : DRAW_640X2;
    end else begin
      result_o.draw_mode = ext_d[EB_16COL] ? DRAW_16COLOR : DRAW_320X4;
    end
    result_o.char_width   = ext_d[EB_16COL] ? CHAR_NARROW : CHAR_WIDE;
    result_o.crt_base     = ram_base_i + {3'd0, crt_page_d, 14'd0};
    result_o.cpu_base     = ram_base_i + {3'd0, cpu_page_d, 14'd0};
    result_o.window_valid = (ram_base_i != UNMAPPED_BASE);
    result_o.window_size  = cpu_page_d[0] ? WIN_SMALL : WIN_LARGE;
    result_o.address_mode = am_d;
    result_o.row_palette  = row_pal_d;
    result_o.border_color = border_d;
    result_o.palette_mask = mask_d;
    result_o.tick_enable  = tick;
  end

endmodule

// ===== hw/rtl/vgar_out_reg.sv =====
// result register toward the master stream
module vgar_out_reg import vgar_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_valid_i,
  output logic    load_ready_o,
  input  result_t result_i,
  output logic    valid_o,
  input  logic    ready_i,
  output result_t result_o
);

  logic    valid_q;
  result_t result_q;

  assign load_ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_ready_o) begin
      valid_q <= load_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_valid_i && load_ready_o) begin
      result_q <= result_i;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

endmodule

// ===== hw/rtl/video_gate_array_registers.sv =====
// top level of the video gate array register file
//
// One transaction on the slave stream is a port write, a status read, an
// end-of-row event or a dot-clock tick; each gives exactly one result
// transaction carrying the status byte, the decoded display setup and the
// tick enable. A transaction enters the input register, is decoded against
// the register state combinationally and lands in the result register, so the
// block takes one transaction per cycle while the master side does not stall,
// and the result register offers the result on the master stream. A stalled
// master side holds the result register and, through it, the input register.
// The video RAM base is set over the APB port at byte address 0 and should
// only change while the stream is idle.
module video_gate_array_registers import vgar_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // slave stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // port_offset[3:0], write_data[11:4], display_area[12], vsync[13]
  input  logic [S_TDATA_W-1:0]  s_axis_tdata,
  // cmd[1:0]
  input  logic [S_TUSER_W-1:0]  s_axis_tuser,
  // master stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // read_data[7:0], draw_mode[10:8], char_width[14:11], crt_base[34:15],
  // cpu_base[54:35], window_valid[55], window_size[71:56],
  // address_mode[73:72], row_palette[89:74], border_color[93:90],
  // palette_mask[97:94], tick_enable[98]
  output logic [M_TDATA_W-1:0]  m_axis_tdata,
  // configuration
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic                  base_sel;
  logic [RAM_BASE_W-1:0] ram_base_q;
  item_t                 s_item;
  item_t                 cur_item;
  logic                  cur_valid;
  logic                  out_ready;
  logic                  fire;
  result_t               core_res;
  result_t               out_res;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ram_base_q <= '0;
    end else if (psel && penable && pwrite && pready && (paddr == REG_RAM_BASE)) begin
      ram_base_q <= pwdata[RAM_BASE_W-1:0];
    end
  end

  // read decode for the base register
  assign base_sel = (paddr == REG_RAM_BASE);
  assign prdata = base_sel ? {{(CFG_DATA_W-RAM_BASE_W){1'b0}}, ram_base_q} : '0;

  assign s_item.cmd          = cmd_e'(s_axis_tuser);
  assign s_item.port_offset  = s_axis_tdata[3:0];
  assign s_item.write_data   = s_axis_tdata[11:4];
  assign s_item.display_area = s_axis_tdata[12];
  assign s_item.vsync        = s_axis_tdata[13];

  assign fire = cur_valid && out_ready;

  vgar_in_reg u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_item_i  (s_item),
    .valid_o    (cur_valid),
    .take_i     (fire),
    .item_o     (cur_item)
  );

  vgar_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (fire),
    .item_i     (cur_item),
    .ram_base_i (ram_base_q),
    .result_o   (core_res)
  );

  vgar_out_reg u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_valid_i (cur_valid),
    .load_ready_o (out_ready),
    .result_i     (core_res),
    .valid_o      (m_axis_tvalid),
    .ready_i      (m_axis_tready),
    .result_o     (out_res)
  );

  assign m_axis_tdata = {5'd0,
                         out_res.tick_enable,
                         out_res.palette_mask,
                         out_res.border_color,
                         out_res.row_palette,
                         out_res.address_mode,
                         out_res.window_size,
                         out_res.window_valid,
                         out_res.cpu_base,
                         out_res.crt_base,
                         out_res.char_width,
                         out_res.draw_mode,
                         out_res.read_data};

endmodule

// ===== hw/rtl/vgar_checker.sv =====
// port-level checks for the video gate array register file
module vgar_checker import vgar_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [M_TDATA_W-1:0] m_axis_tdata
);

  logic [7:0]  rd;
  logic [2:0]  dm;
  logic [3:0]  cw;
  logic [15:0] ws;
  logic        tk;

  assign rd = m_axis_tdata[OF_READ_DATA +: 8];
  assign dm = m_axis_tdata[OF_DRAW_MODE +: 3];
  assign cw = m_axis_tdata[OF_CHAR_W +: 4];
  assign ws = m_axis_tdata[OF_WIN_SIZE +: 16];
  assign tk = m_axis_tdata[OF_TICK];

  // a stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // a tick never carries status data
  a_tick_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && tk |-> rd == 8'd0)
    else $error("tick result with status byte");

  // sixteen-colour mode implies narrow characters
  a_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && dm == DRAW_16COLOR |-> cw == CHAR_NARROW)
    else $error("sixteen-colour mode with wide characters");

  a_win: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ws == WIN_SMALL || ws == WIN_LARGE)
    else $error("bad window size");

endmodule

bind video_gate_array_registers vgar_checker u_vgar_checker (.*);

// ===== test/tb.sv =====
// self-checking stream and apb testbench for the video gate array register file
`timescale 1ns / 1ps

module tb;
  import vgar_pkg::*;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [S_TDATA_W-1:0]  s_axis_tdata = '0;
  logic [S_TUSER_W-1:0]  s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0]  m_axis_tdata;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  video_gate_array_registers u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  item_t   bus_items[$];
  result_t setup_expected[$];
  int      mismatches = 0;
  bit      quiet_tail = 1'b0;
  int      src_gap = 0;
  int      sink_stall = 0;

  // shadow of the register file
  logic [RAM_BASE_W-1:0] ram_base;
  logic [5:0]            mode_bits;
  logic [2:0]            ext_bits;
  logic [5:0]            color_sel;
  logic [2:0]            crt_pg;
  logic [2:0]            cpu_pg;
  addr_mode_e            addr_mode;
  logic [7:0]            array_addr;
  logic [3:0]            palette_regs [PALETTE_ENTRIES];
  logic [3:0]            mask_reg;
  logic [3:0]            border_reg;
  logic [15:0]           row_pal;
  logic                  tick_div;

  function automatic void clear_shadow();
    ram_base   = '0;
    mode_bits  = '0;
    ext_bits   = '0;
    color_sel  = '0;
    crt_pg     = '0;
    cpu_pg     = '0;
    addr_mode  = AM_ALPHA;
    array_addr = '0;
    for (int i = 0; i < PALETTE_ENTRIES; i++) palette_regs[i] = '0;
    mask_reg   = '0;
    border_reg = '0;
    row_pal    = '0;
    tick_div   = 1'b0;
  endfunction

  function automatic result_t next_display_setup(item_t it);
    result_t r;
    r = '0;
    case (it.cmd)
      CMD_WRITE: begin
        case (it.port_offset)
          PORT_MODE:  mode_bits = it.write_data[5:0];
          PORT_COLOR: color_sel = it.write_data[5:0];
          PORT_ADDR:  array_addr = it.write_data;
          PORT_DATA: begin
            if (array_addr[4]) palette_regs[array_addr[3:0]] = it.write_data[3:0];
            else if (array_addr == ARR_MASK) mask_reg = it.write_data[3:0];
            else if (array_addr == ARR_BORDER) border_reg = it.write_data[3:0];
            else if (array_addr == ARR_EXT_MODE) ext_bits = it.write_data[4:2];
          end
          PORT_PAGE: begin
            crt_pg = it.write_data[2:0];
            cpu_pg = it.write_data[5:3];
            if (mode_bits[MB_GRAPHICS] && mode_bits[MB_HI_DOT]) crt_pg[0] = 1'b0;
            case (it.write_data[7:6])
              PG_AM_ALPHA: addr_mode = AM_ALPHA;
              PG_AM_LOW:   addr_mode = AM_GFX_LOW;
              PG_AM_HIGH:  addr_mode = AM_GFX_HIGH;
              default:     ;
            endcase
          end
          default: ;
        endcase
      end
      CMD_STATUS: begin
        if (it.port_offset == PORT_ADDR)
          r.read_data = {4'b0, it.vsync, 1'b1, 1'b0, ~it.display_area};
      end
      CMD_ROW_END: begin
        row_pal = {12'b0, ext_bits[EB_BORDER] ? border_reg : color_sel[3:0]};
        // color select bit 4 is intensity, bit 5 the palette select
        for (int i = 1; i < 4; i++)
          row_pal[4*i +: 4] = {color_sel[4], i[1:0],
                               (color_sel[5] & ~mode_bits[MB_MONO]) |
                               (mode_bits[MB_MONO] & i[0])};
      end
      default: begin
        if (mode_bits[MB_HI_DOT]) begin
          r.tick_enable = 1'b1;
        end else begin
          tick_div = ~tick_div;
          r.tick_enable = ~tick_div;
        end
      end
    endcase

    if (!mode_bits[MB_GRAPHICS]) r.draw_mode = DRAW_TEXT;
    else if (mode_bits[MB_HI_RES]) r.draw_mode = ext_bits[EB_640X4] ? DRAW_640X4 : DRAW_640X2;
    else r.draw_mode = ext_bits[EB_16COL] ? DRAW_16COLOR : DRAW_320X4;
    r.char_width   = ext_bits[EB_16COL] ? CHAR_NARROW : CHAR_WIDE;
    r.crt_base     = ram_base + {3'b0, crt_pg, 14'b0};
    r.cpu_base     = ram_base + {3'b0, cpu_pg, 14'b0};
    r.window_valid = (ram_base != UNMAPPED_BASE);
    r.window_size  = cpu_pg[0] ? WIN_SMALL : WIN_LARGE;
    r.address_mode = addr_mode;
    r.row_palette  = row_pal;
    r.border_color = border_reg;
    r.palette_mask = mask_reg;
    return r;
  endfunction

  function automatic result_t unpack_setup(logic [M_TDATA_W-1:0] d);
    result_t r;
    r.read_data    = d[OF_READ_DATA +: 8];
    r.draw_mode    = d[OF_DRAW_MODE +: 3];
    r.char_width   = d[OF_CHAR_W +: 4];
    r.crt_base     = d[OF_CRT_BASE +: RAM_BASE_W];
    r.cpu_base     = d[OF_CPU_BASE +: RAM_BASE_W];
    r.window_valid = d[OF_WIN_VALID];
    r.window_size  = d[OF_WIN_SIZE +: 16];
    r.address_mode = addr_mode_e'(d[OF_ADDR_MODE +: 2]);
    r.row_palette  = d[OF_ROW_PAL +: 16];
    r.border_color = d[OF_BORDER +: 4];
    r.palette_mask = d[OF_MASK +: 4];
    r.tick_enable  = d[OF_TICK];
    return r;
  endfunction

  function automatic void check_field(string name, logic [19:0] want, logic [19:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t %s: expected %0h, got %0h", $time, name, want, got);
    end
  endfunction

  // driver: one stream transaction offered at a time, random gaps between
  always @(posedge clk_i) begin
    item_t it;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (src_gap > 0) begin
        src_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
        src_gap = $urandom_range(0, 4);
        s_axis_tvalid <= 1'b0;
      end else if (bus_items.size() > 0) begin
        it = bus_items.pop_front();
        s_axis_tdata  <= {2'b0, it.vsync, it.display_area, it.write_data, it.port_offset};
        s_axis_tuser  <= it.cmd;
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // result side back-pressure
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (sink_stall > 0) begin
      sink_stall--;
      m_axis_tready <= 1'b0;
    end else if (!quiet_tail && $urandom_range(0, 15) == 0) begin
      sink_stall = $urandom_range(0, 4);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // monitor: compare results, predict accepted items, track the apb port
  always @(posedge clk_i) begin
    item_t   it;
    result_t want;
    result_t got;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = unpack_setup(m_axis_tdata);
        if (setup_expected.size() == 0) begin
          mismatches++;
          $display("%0t result with nothing expected: %0h", $time, m_axis_tdata);
        end else begin
          want = setup_expected.pop_front();
          check_field("read_data", want.read_data, got.read_data);
          check_field("draw_mode", want.draw_mode, got.draw_mode);
          check_field("char_width", want.char_width, got.char_width);
          check_field("crt_base", want.crt_base, got.crt_base);
          check_field("cpu_base", want.cpu_base, got.cpu_base);
          check_field("window_valid", want.window_valid, got.window_valid);
          check_field("window_size", want.window_size, got.window_size);
          check_field("address_mode", want.address_mode, got.address_mode);
          check_field("row_palette", want.row_palette, got.row_palette);
          check_field("border_color", want.border_color, got.border_color);
          check_field("palette_mask", want.palette_mask, got.palette_mask);
          check_field("tick_enable", want.tick_enable, got.tick_enable);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        it.cmd          = cmd_e'(s_axis_tuser);
        it.port_offset  = s_axis_tdata[3:0];
        it.write_data   = s_axis_tdata[11:4];
        it.display_area = s_axis_tdata[12];
        it.vsync        = s_axis_tdata[13];
        setup_expected.push_back(next_display_setup(it));
      end
      if (psel && penable && pready && paddr == REG_RAM_BASE) begin
        if (pwrite)
          ram_base = pwdata[RAM_BASE_W-1:0];
        else
          check_field("prdata", ram_base, prdata[RAM_BASE_W-1:0]);
      end
    end
  end

  function automatic void push_item(cmd_e c, logic [3:0] p, logic [7:0] d);
    item_t it;
    it.cmd          = c;
    it.port_offset  = p;
    it.write_data   = d;
    it.display_area = 1'($urandom_range(0, 1));
    it.vsync        = 1'($urandom_range(0, 1));
    bus_items.push_back(it);
  endfunction

  function automatic void push_status(logic [3:0] p, logic disp, logic vs);
    item_t it;
    it.cmd          = CMD_STATUS;
    it.port_offset  = p;
    it.write_data   = 8'($urandom_range(0, 255));
    it.display_area = disp;
    it.vsync        = vs;
    bus_items.push_back(it);
  endfunction

  function automatic logic [7:0] pick_array_addr();
    case ($urandom_range(0, 5))
      0:       return ARR_MASK;
      1:       return ARR_BORDER;
      2:       return ARR_EXT_MODE;
      3:       return {4'h1, 4'($urandom_range(0, 15))};
      4:       return {3'($urandom_range(0, 7)), 1'b1, 4'($urandom_range(0, 15))};
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // one random sequence, returns how many transactions it queued
  function automatic int push_random_sequence();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) begin
      push_item(CMD_TICK, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
      return 1;
    end else if (r < 52) begin
      push_item(CMD_ROW_END, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
      return 1;
    end else if (r < 62) begin
      push_status(($urandom_range(0, 3) != 0) ? PORT_ADDR : 4'($urandom_range(0, 15)),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      return 1;
    end else if (r < 78) begin
      // address then data, the usual way the array is loaded
      push_item(CMD_WRITE, PORT_ADDR, pick_array_addr());
      push_item(CMD_WRITE, PORT_DATA, 8'($urandom_range(0, 255)));
      return 2;
    end else if (r < 85) begin
      push_item(CMD_WRITE, PORT_MODE, 8'($urandom_range(0, 255)));
      return 1;
    end else if (r < 90) begin
      push_item(CMD_WRITE, PORT_COLOR, 8'($urandom_range(0, 255)));
      return 1;
    end else if (r < 96) begin
      push_item(CMD_WRITE, PORT_PAGE, 8'($urandom_range(0, 255)));
      return 1;
    end
    // noise: any port, including the unused ones and a lone data write
    push_item(CMD_WRITE, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
    return 1;
  endfunction

  task automatic apb_access(input logic wr, input logic [CFG_ADDR_W-1:0] addr,
                            input logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic wait_idle();
    do @(negedge clk_i);
    while (bus_items.size() != 0 || setup_expected.size() != 0 || s_axis_tvalid);
    // input and result registers, let the pipeline drain fully
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    logic [RAM_BASE_W-1:0] base_plan [6];
    int queued;
    clear_shadow();
    base_plan[0] = 20'h00000;
    base_plan[1] = UNMAPPED_BASE;
    base_plan[2] = 20'hFFFFF;
    base_plan[3] = 20'($urandom_range(0, 20'hFFFFF));
    base_plan[4] = 20'hFC000;
    base_plan[5] = 20'($urandom_range(0, 20'hFFFFF));
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int ph = 0; ph < 6; ph++) begin
      wait_idle();
      apb_access(1'b1, REG_RAM_BASE,
                 {12'($urandom_range(0, 12'hFFF)), base_plan[ph]});
      apb_access(1'b0, REG_RAM_BASE, '0);
      if (ph == 2) begin
        // a write to the next word must leave the base alone
        apb_access(1'b1, 3'd4, $urandom);
        apb_access(1'b0, REG_RAM_BASE, '0);
      end
      if (ph == 5) quiet_tail = 1'b1;

      if (ph == 0) begin
        push_status(PORT_ADDR, 1'b1, 1'b0);
        push_status(PORT_ADDR, 1'b0, 1'b1);
        push_status(4'd3, 1'b0, 1'b1);
        push_item(CMD_TICK, 4'd0, 8'h00);
        push_item(CMD_TICK, 4'd15, 8'hFF);
        push_item(CMD_WRITE, PORT_MODE, 8'hFF);
        push_item(CMD_TICK, 4'd0, 8'h00);
        push_item(CMD_WRITE, PORT_PAGE, 8'hFF);   // crt page bit 0 dropped
        push_item(CMD_WRITE, PORT_PAGE, 8'h80);   // reserved address mode
        push_item(CMD_WRITE, PORT_ADDR, ARR_EXT_MODE);
        push_item(CMD_WRITE, PORT_DATA, 8'hFF);
        push_item(CMD_WRITE, PORT_MODE, 8'h02);
        push_item(CMD_WRITE, PORT_ADDR, ARR_MASK);
        push_item(CMD_WRITE, PORT_DATA, 8'hFF);
        push_item(CMD_WRITE, PORT_ADDR, ARR_BORDER);
        push_item(CMD_WRITE, PORT_DATA, 8'h0A);
        push_item(CMD_WRITE, PORT_COLOR, 8'hFF);
        push_item(CMD_ROW_END, 4'd0, 8'h00);
        push_item(CMD_WRITE, PORT_MODE, 8'h04);   // mono
        push_item(CMD_ROW_END, 4'd0, 8'h00);
        push_item(CMD_WRITE, PORT_ADDR, 8'hFF);   // palette index masked
        push_item(CMD_WRITE, PORT_DATA, 8'h05);
        push_item(CMD_WRITE, PORT_ADDR, 8'h04);   // ignored array address
        push_item(CMD_WRITE, PORT_DATA, 8'hFF);
        push_item(CMD_WRITE, 4'd0, 8'hFF);        // unused port
        push_item(CMD_WRITE, PORT_PAGE, 8'h49);
        push_item(CMD_WRITE, PORT_PAGE, 8'h00);
      end

      queued = 0;
      while (queued < 300) queued += push_random_sequence();
    end

    wait_idle();
    repeat (5) @(posedge clk_i);
    if (mismatches == 0)
      $display("tb: PASS");
    else
      $display("tb: FAIL");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb: FAIL");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/vgar_pkg.sv
hw/rtl/vgar_in_reg.sv
hw/rtl/vgar_core.sv
hw/rtl/vgar_out_reg.sv
hw/rtl/video_gate_array_registers.sv
hw/rtl/vgar_checker.sv
test/tb.sv
